### hw/rtl/shfd_pkg.sv
// Shared constants, command type and header helpers for the sync-header frame deframer.
package shfd_pkg;

	localparam int FRAME_BYTES_DEF = 36;
	localparam int HDR_LEN         = 8;
	localparam int PAY_LEN         = 24;
	localparam int CHK_POS         = 32;
	localparam int WORD_BYTES      = 4;
	localparam int NUM_WORDS       = 6;
	localparam int WORD_W          = 32;
	localparam int DATA_W          = NUM_WORDS * WORD_W;
	localparam int SLOT_W          = $clog2(PAY_LEN);
	localparam int QDEPTH          = 4;
	localparam int QPTR_W          = $clog2(QDEPTH);

	// Sync header as it sits in the shift window, first byte in the top byte.
	localparam logic [63:0] HDR_VALUE = 64'h2441_5556_3230_3030;

	// Modulo-256 sum of the eight header bytes.
	function automatic logic [7:0] header_sum();
		logic [7:0] s;
		s = 8'd0;
		for (int k = 0; k < HDR_LEN; k++) begin
			s = s + HDR_VALUE[8*k +: 8];
		end
		return s;
	endfunction

	localparam logic [7:0] HDR_SUM = header_sum();

	// One classified item handed from the front to the back.
	typedef struct packed {
		logic              is_check;  // 1: checksum byte, emit a result
		logic              status;    // checksum mismatch flag (check only)
		logic [SLOT_W-1:0] slot;      // payload slot (payload only)
		logic [7:0]        data;      // payload byte (payload only)
	} cmd_t;

endpackage

### hw/rtl/shfd_front.sv
// Front part: accepts bytes, hunts for the header, tracks position and checksum.
module shfd_front #(
	parameter int FRAME_BYTES = shfd_pkg::FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	output logic          push_valid,
	input  logic          push_ready,
	output shfd_pkg::cmd_t push_cmd
);
	import shfd_pkg::*;

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_HDR   = POS_W'(HDR_LEN);
	localparam logic [POS_W-1:0] POS_CHK   = POS_W'(CHK_POS);
	localparam logic [POS_W-1:0] POS_AFTER =
		(CHK_POS + 1 < FRAME_BYTES) ? POS_W'(CHK_POS + 1) : '0;
	localparam logic [POS_W:0]   POS_LIMIT = (POS_W+1)'(FRAME_BYTES);

	logic              enable_q;
	logic [63:0]       win_q, win_d, win_shift;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [7:0]        sum_q, sum_d;
	logic [POS_W:0]    pos_inc;
	logic              accept;

	assign in_ready  = push_ready;
	assign accept    = in_valid && in_ready;
	assign win_shift = {win_q[55:0], in_byte};
	assign pos_inc   = {1'b0, pos_q} + (POS_W+1)'(1);

	always_comb begin
		win_d      = win_q;
		pos_d      = pos_q;
		sum_d      = sum_q;
		push_valid = 1'b0;
		push_cmd   = '0;
		if (accept && enable_q) begin
			if (pos_q < POS_HDR) begin
				if (win_shift == HDR_VALUE) begin
					win_d = '0;
					sum_d = HDR_SUM;
					pos_d = POS_HDR;
				end else begin
					win_d = win_shift;
					pos_d = '0;
				end
			end else if (pos_q < POS_CHK) begin
				push_valid    = 1'b1;
				push_cmd.slot = SLOT_W'(pos_q - POS_HDR);
				push_cmd.data = in_byte;
				sum_d         = sum_q + in_byte;
				pos_d         = pos_inc[POS_W-1:0];
			end else if (pos_q == POS_CHK) begin
				push_valid        = 1'b1;
				push_cmd.is_check = 1'b1;
				push_cmd.status   = (in_byte != (8'd0 - sum_q));
				pos_d             = POS_AFTER;
			end else begin
				pos_d = (pos_inc < POS_LIMIT) ? pos_inc[POS_W-1:0] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			win_q    <= '0;
			pos_q    <= '0;
			sum_q    <= '0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			win_q <= win_d;
			pos_q <= pos_d;
			sum_q <= sum_d;
		end
	end

endmodule

### hw/rtl/shfd_queue.sv
// Short command queue that decouples the front from the back.
module shfd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  shfd_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output shfd_pkg::cmd_t out_cmd
);
	import shfd_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push, pop;

	assign in_ready  = (count_q != (QPTR_W+1)'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hw/rtl/shfd_back.sv
// Back part: stores payload bytes and loads the result register on the checksum byte.
module shfd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  shfd_pkg::cmd_t              cmd,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [shfd_pkg::DATA_W-1:0] m_tdata,
	output logic [0:0]                  m_tuser
);
	import shfd_pkg::*;

	logic [7:0]        store_q [PAY_LEN];
	logic [DATA_W-1:0] words;
	logic [DATA_W-1:0] data_q;
	logic              status_q;
	logic              valid_q;
	logic              out_free;
	logic              pop;

	assign out_free  = !valid_q || m_tready;
	assign cmd_ready = !cmd.is_check || out_free;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			for (int k = 0; k < WORD_BYTES; k++) begin
				words[w*WORD_W + 8*k +: 8] = store_q[w*WORD_BYTES + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !cmd.is_check) begin
			store_q[cmd.slot] <= cmd.data;
		end
		if (pop && cmd.is_check) begin
			data_q   <= words;
			status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && cmd.is_check) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid   = valid_q;
	assign m_tdata    = data_q;
	assign m_tuser[0] = status_q;

endmodule

### hw/rtl/sync_header_frame_deframer_top.sv
// Top level of the sync-header frame deframer: front, command queue and back.
// Throughput: one byte per cycle; s_tready drops only while the queue is full,
// which happens when a result waits in the output register and is not taken.
// Result path: an accepted checksum byte is written into the queue, then popped by the back end,
// which loads the output register and raises m_tvalid when that register is free.
// Reset: arst_n clears enable, window, position, sum, queue and valid, not store, data or status.
module sync_header_frame_deframer_top #(
	parameter int FRAME_BYTES = shfd_pkg::FRAME_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,  // receive_enable
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,    // rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// total_word, capacity_word, used_word, percentage_word, current_word,
	// voltage_word, 32 bits each from bit 0 up
	output logic [shfd_pkg::DATA_W-1:0] m_tdata,
	output logic [0:0]                  m_tuser     // frame_status
);
	import shfd_pkg::*;

	cmd_t push_cmd, pop_cmd;
	logic push_valid, push_ready;
	logic pop_valid, pop_ready;

	// Front: classify each item and keep the hunting and checksum state.
	shfd_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	// Queue: hold payload writes behind a stalled result so the front keeps going.
	shfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_cmd   (push_cmd),
		.out_valid(pop_valid),
		.out_ready(pop_ready),
		.out_cmd  (pop_cmd)
	);

	// Back: write the payload store, build the six words on the checksum item.
	shfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(pop_valid),
		.cmd_ready(pop_ready),
		.cmd      (pop_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### hw/rtl/shfd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
module shfd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [shfd_pkg::DATA_W-1:0] m_tdata
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// Input backpressure only comes from a result waiting at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// No result right out of reset.
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

endmodule

bind sync_header_frame_deframer_top shfd_checker u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
